// ===== src/kdlpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlpr_pkg
// Shared types and constants for the key debounce / long press / repeat block.
// ----------------------------------------------------------------------------
package kdlpr_pkg;

   // key count and derived widths
   localparam int KEYS    = 8;
   localparam int KEY_W   = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int FIELD_W = 8;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;

   // stream payload widths
   localparam int REQ_W = TIME_W + 2 * FIELD_W;
   localparam int RSP_W = 2 * FIELD_W;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_START = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT     = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_START_RST = 16'd500;
   localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd100;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic step;
      logic load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_key;
      logic out_free;
   } ctrl_sts_type;

   // timing settings bundle
   typedef struct packed {
      logic [CFG_W-1:0] settle_ms;
      logic [CFG_W-1:0] long_start_ms;
      logic [CFG_W-1:0] repeat_ms;
   } cfg_type;

endpackage

// ===== src/key_debounce_long_press_repeat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_long_press_repeat
// Sequence: a poll is taken while idle, the shared per-key update unit walks
//   the keys one per cycle, then the result is loaded once the output slot is
//   free. A new poll is not taken until that load is done.
// Reset: synchronous; all keys idle with zero times, timings 50/500/100 ms.
// Debounces polled keys and reports short presses and long press repeats.
// ----------------------------------------------------------------------------
module key_debounce_long_press_repeat (
   input  logic                             clock,
   input  logic                             reset,
   // poll stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kdlpr_pkg::REQ_W-1:0]      req_tdata,  // now_ms, pending_mask, key_levels
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kdlpr_pkg::RSP_W-1:0]      rsp_tdata,  // short_mask, repeat_mask
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kdlpr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kdlpr_pkg::CFG_W-1:0]      csr_data
);

   localparam int TW = kdlpr_pkg::TIME_W;
   localparam int FW = kdlpr_pkg::FIELD_W;

   kdlpr_pkg::cfg_type      cfg_ff;
   kdlpr_pkg::ctrl_cmd_type cmd;
   kdlpr_pkg::ctrl_sts_type sts;
   logic [FW-1:0]           rsp_short, rsp_repeat;

   // timing registers, unknown indexes dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ms     <= kdlpr_pkg::DEBOUNCE_RST;
         cfg_ff.long_start_ms <= kdlpr_pkg::LONG_START_RST;
         cfg_ff.repeat_ms     <= kdlpr_pkg::REPEAT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            kdlpr_pkg::CSR_DEBOUNCE:   cfg_ff.settle_ms     <= csr_data;
            kdlpr_pkg::CSR_LONG_START: cfg_ff.long_start_ms <= csr_data;
            kdlpr_pkg::CSR_REPEAT:     cfg_ff.repeat_ms     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   kdlpr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .sts      (sts),
      .cmd      (cmd)
   );

   kdlpr_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .cfg        (cfg_ff),
      .in_now_ms  (req_tdata[TW-1:0]),
      .in_pending (req_tdata[TW+FW-1:TW]),
      .in_levels  (req_tdata[TW+2*FW-1:TW+FW]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_short  (rsp_short),
      .out_repeat (rsp_repeat)
   );

   assign rsp_tdata = {rsp_repeat, rsp_short};

endmodule

// ===== src/kdlpr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlpr_ctrl
// Sequencer: takes a poll, walks the keys one per cycle, then loads the result.
// ----------------------------------------------------------------------------
module kdlpr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  kdlpr_pkg::ctrl_sts_type sts,
   output kdlpr_pkg::ctrl_cmd_type cmd
);

   kdlpr_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kdlpr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      unique case (state_ff)
         kdlpr_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.start = 1'b1;
               state_in  = kdlpr_pkg::ST_SCAN;
            end
         end
         kdlpr_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.last_key) begin
               state_in = kdlpr_pkg::ST_DONE;
            end
         end
         kdlpr_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = kdlpr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kdlpr_pkg::ST_IDLE;
         end
      endcase
   end

   // result only loaded into a free output slot
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> sts.out_free)
      else $error("result loaded while output slot busy");

   // a taken poll is always scanned next
   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == kdlpr_pkg::ST_SCAN))
      else $error("scan did not follow poll accept");

   // scan ends after the last key
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kdlpr_pkg::ST_SCAN && sts.last_key) |=> (state_ff == kdlpr_pkg::ST_DONE))
      else $error("scan did not end after last key");

   // no two of start, step and load together
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.step, cmd.load}))
      else $error("conflicting datapath commands");

endmodule

// ===== src/kdlpr_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlpr_dpath
// Per-key state, time differences, event masks and the result register.
// ----------------------------------------------------------------------------
module kdlpr_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  kdlpr_pkg::ctrl_cmd_type            cmd,
   output kdlpr_pkg::ctrl_sts_type            sts,
   input  kdlpr_pkg::cfg_type                 cfg,
   input  logic [kdlpr_pkg::TIME_W-1:0]       in_now_ms,
   input  logic [kdlpr_pkg::FIELD_W-1:0]      in_pending,
   input  logic [kdlpr_pkg::FIELD_W-1:0]      in_levels,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [kdlpr_pkg::FIELD_W-1:0]      out_short,
   output logic [kdlpr_pkg::FIELD_W-1:0]      out_repeat
);

   localparam int TW = kdlpr_pkg::TIME_W;
   localparam int FW = kdlpr_pkg::FIELD_W;
   localparam int KW = kdlpr_pkg::KEY_W;
   localparam int NK = kdlpr_pkg::KEYS;

   // per-key state
   logic          down_ff   [NK];
   logic          long_ff   [NK];
   logic [TW-1:0] press_ff  [NK];
   logic [TW-1:0] change_ff [NK];
   logic [TW-1:0] rep_ff    [NK];

   // captured poll and scan position
   logic [TW-1:0] now_ff;
   logic [FW-1:0] pend_ff;
   logic [FW-1:0] lev_ff;
   logic [KW-1:0] key_idx_ff;
   logic [FW-1:0] short_acc_ff;
   logic [FW-1:0] rep_acc_ff;

   // result register
   logic          out_valid_ff;
   logic [FW-1:0] out_short_ff;
   logic [FW-1:0] out_repeat_ff;

   // current key view
   logic [FW-1:0] field_sel;
   logic          pend_bit, lev_bit;
   logic          down_cur, long_cur;
   logic [TW-1:0] press_cur, change_cur, rep_cur;
   logic [TW-1:0] d_change, d_press, d_rep;
   logic          edge_ok;
   logic          down_in, long_in;
   logic [TW-1:0] press_in, change_in, rep_in;
   logic          short_hit, rep_hit;

   assign field_sel  = FW'(1) << key_idx_ff;
   assign pend_bit   = |(pend_ff & field_sel);
   assign lev_bit    = |(lev_ff & field_sel);
   assign down_cur   = down_ff[key_idx_ff];
   assign long_cur   = long_ff[key_idx_ff];
   assign press_cur  = press_ff[key_idx_ff];
   assign change_cur = change_ff[key_idx_ff];
   assign rep_cur    = rep_ff[key_idx_ff];

   // modulo 2^32 time differences
   assign d_change = now_ff - change_cur;
   assign d_press  = now_ff - press_cur;
   assign d_rep    = now_ff - rep_cur;

   // edge handling then hold handling for one key
   always_comb begin
      edge_ok   = pend_bit && (d_change >= TW'(cfg.settle_ms));
      down_in   = down_cur;
      long_in   = long_cur;
      press_in  = press_cur;
      rep_in    = rep_cur;
      change_in = pend_bit ? now_ff : change_cur;
      short_hit = 1'b0;
      rep_hit   = 1'b0;
      if (edge_ok) begin
         down_in  = lev_bit;
         long_in  = 1'b0;
         press_in = lev_bit ? now_ff : '0;
         rep_in   = '0;
         short_hit = !lev_bit && down_cur && !long_cur;
      end
      if (down_in) begin
         if (!long_in) begin
            // a fresh press has held for zero time
            if ((edge_ok ? TW'(0) : d_press) >= TW'(cfg.long_start_ms)) begin
               long_in = 1'b1;
               rep_in  = now_ff;
            end
         end else if (d_rep >= TW'(cfg.repeat_ms)) begin
            rep_in  = now_ff;
            rep_hit = 1'b1;
         end
      end
   end

   // key state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NK; k++) begin
            down_ff[k]   <= 1'b0;
            long_ff[k]   <= 1'b0;
            press_ff[k]  <= '0;
            change_ff[k] <= '0;
            rep_ff[k]    <= '0;
         end
      end else if (cmd.step) begin
         down_ff[key_idx_ff]   <= down_in;
         long_ff[key_idx_ff]   <= long_in;
         press_ff[key_idx_ff]  <= press_in;
         change_ff[key_idx_ff] <= change_in;
         rep_ff[key_idx_ff]    <= rep_in;
      end
   end

   // poll capture, scan counter and event masks
   always_ff @(posedge clock) begin
      if (reset) begin
         key_idx_ff   <= '0;
         short_acc_ff <= '0;
         rep_acc_ff   <= '0;
      end else if (cmd.start) begin
         key_idx_ff   <= '0;
         short_acc_ff <= '0;
         rep_acc_ff   <= '0;
      end else if (cmd.step) begin
         key_idx_ff   <= key_idx_ff + KW'(1);
         short_acc_ff <= short_acc_ff | (short_hit ? field_sel : '0);
         rep_acc_ff   <= rep_acc_ff | (rep_hit ? field_sel : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         now_ff  <= in_now_ms;
         pend_ff <= in_pending;
         lev_ff  <= in_levels;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_short_ff  <= short_acc_ff;
         out_repeat_ff <= rep_acc_ff;
      end
   end

   assign sts.last_key = (key_idx_ff == KW'(NK - 1));
   assign sts.out_free = !out_valid_ff || out_ready;
   assign out_valid    = out_valid_ff;
   assign out_short    = out_short_ff;
   assign out_repeat   = out_repeat_ff;

endmodule
